[rtl/i2cm_pkg.sv]
// Shared types and constants for the I2C register-access master.
package i2cm_pkg;

   localparam int MaxTransferDefault = 16;

   localparam logic [2:0] OP_TICK    = 3'd0;
   localparam logic [2:0] OP_QUEUE   = 3'd1;
   localparam logic [2:0] OP_WRITE   = 3'd2;
   localparam logic [2:0] OP_READ    = 3'd3;
   localparam logic [2:0] OP_RECOVER = 3'd4;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_TIMEOUT = 3'd1;
   localparam logic [2:0] ST_BUSY    = 3'd2;
   localparam logic [2:0] ST_ANACK   = 3'd3;
   localparam logic [2:0] ST_DNACK   = 3'd4;
   localparam logic [2:0] ST_INVALID = 3'd5;

   localparam logic CSR_HALF    = 1'b0;
   localparam logic CSR_STRETCH = 1'b1;

   localparam logic [3:0] RECOVERY_PULSES = 4'd9;

   typedef enum logic [15:0] {
      P_IDLE     = 16'h0001,
      P_ST_REL   = 16'h0002,
      P_ST_WAIT  = 16'h0004,
      P_ST_D1    = 16'h0008,
      P_ST_D2    = 16'h0010,
      P_BY_D1    = 16'h0020,
      P_BY_WAIT  = 16'h0040,
      P_BY_D2    = 16'h0080,
      P_SP_D1    = 16'h0100,
      P_SP_WAIT  = 16'h0200,
      P_SP_D2    = 16'h0400,
      P_SP_D3    = 16'h0800,
      P_RC_WAIT0 = 16'h1000,
      P_RC_D1    = 16'h2000,
      P_RC_WAIT  = 16'h4000,
      P_RC_D2    = 16'h8000
   } phase_type;

   typedef enum logic [2:0] {
      SEG_START   = 3'd0,
      SEG_ADDR_W  = 3'd1,
      SEG_REG     = 3'd2,
      SEG_DATA_W  = 3'd3,
      SEG_RSTART  = 3'd4,
      SEG_ADDR_R  = 3'd5,
      SEG_DATA_R  = 3'd6,
      SEG_RECOVER = 3'd7
   } seg_type;

   typedef struct packed {
      logic [2:0] operation;
      logic       scl_level;
      logic       sda_level;
      logic [6:0] device_address;
      logic [7:0] register_index;
      logic [4:0] byte_count;
      logic [7:0] write_data;
   } cmd_type;

   typedef struct packed {
      logic       scl_drive_low;
      logic       sda_drive_low;
      logic       busy_res;
      logic       accepted;
      logic       read_valid;
      logic [7:0] read_data;
      logic       read_last;
      logic       done_res;
      logic [2:0] status;
   } rsp_type;

endpackage

[rtl/i2cm_if.sv]
// Valid/ready channel interfaces for commands, results and register writes.
interface i2cm_req_if;
   logic             valid;
   logic             ready;
   i2cm_pkg::cmd_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface i2cm_rsp_if;
   logic             valid;
   logic             ready;
   i2cm_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface i2cm_csr_if;
   logic       valid;
   logic       ready;
   logic       index;
   logic [9:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/i2cm_front.sv]
// Front end: takes command items into a short queue toward the engine.
module i2cm_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  i2cm_pkg::cmd_type in_cmd,
   output logic             q_valid,
   input  logic             q_take,
   output i2cm_pkg::cmd_type q_cmd
);
   // two-entry FIFO
   i2cm_pkg::cmd_type mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (cnt_ff != 2'd0);
   assign pop      = q_valid && q_take;
   assign q_cmd    = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_cmd;
   end
endmodule

[rtl/i2cm_engine.sv]
// Back end: bus sequencer, write queue and result register.
module i2cm_engine #(
   parameter int MaxTransfer = i2cm_pkg::MaxTransferDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_take,
   input  i2cm_pkg::cmd_type q_cmd,
   input  logic [7:0]       half_period,
   input  logic [9:0]       stretch_limit,
   output logic             out_valid,
   input  logic             out_ready,
   output i2cm_pkg::rsp_type out_rsp
);
   localparam int QW = (MaxTransfer > 1) ? $clog2(MaxTransfer) : 1;
   localparam int CW = $clog2(MaxTransfer + 1);

   i2cm_pkg::phase_type phase_ff, phase_in;
   i2cm_pkg::seg_type   seg_ff, seg_in;
   logic [7:0] half_ff, half_in;
   logic [9:0] str_ff, str_in;
   logic [3:0] bit_ff, bit_in;
   logic [4:0] byc_ff, byc_in;
   logic [3:0] rec_ff, rec_in;
   logic [7:0] shift_ff, shift_in;
   logic [6:0] addr_ff, addr_in;
   logic [7:0] reg_ff, reg_in;
   logic [4:0] len_ff, len_in;
   logic       rd_ff, rd_in;
   logic [CW-1:0] qc_ff, qc_in;
   logic       scl_ff, scl_in, sda_ff, sda_in;
   logic [2:0] fst_ff, fst_in;
   logic [7:0] queue_mem [MaxTransfer];
   logic [7:0] qrd;
   logic       qwe;
   logic [QW-1:0] qwa;
   i2cm_pkg::rsp_type r;
   logic       ovalid_ff;
   i2cm_pkg::rsp_type orsp_ff;

   logic [7:0] hlim;
   logic [9:0] slim;
   logic       ddone;
   logic [1:0] wres;
   logic       wr, ack;
   logic [7:0] bval;
   logic       bwr, bgo;
   logic [4:0] byc_nx;
   logic [2:0] op;

   assign q_take    = !ovalid_ff || out_ready;
   assign out_valid = ovalid_ff;
   assign out_rsp   = orsp_ff;
   assign op        = q_cmd.operation;
   assign hlim      = (half_period == 8'd0) ? 8'd1 : half_period;
   assign slim      = (stretch_limit == 10'd0) ? 10'd1 : stretch_limit;
   assign wr        = (seg_ff != i2cm_pkg::SEG_DATA_R);
   assign ack       = !q_cmd.sda_level;
   assign byc_nx    = byc_ff + 5'd1;

   // queue entry read by index; index past depth reads zero
   function automatic logic [7:0] q_at(input logic [4:0] i, input logic [7:0] v);
      q_at = ({27'd0, i} < MaxTransfer) ? v : 8'd0;
   endfunction

   always_comb begin
      qrd = 8'd0;
      for (int k = 0; k < MaxTransfer; k++) begin
         if ({27'd0, byc_nx} == k && seg_ff == i2cm_pkg::SEG_DATA_W) qrd = queue_mem[k];
         if (k == 0 && seg_ff == i2cm_pkg::SEG_REG) qrd = queue_mem[0];
      end
   end

   always_comb begin
      phase_in = phase_ff; seg_in = seg_ff; half_in = half_ff; str_in = str_ff;
      bit_in = bit_ff; byc_in = byc_ff; rec_in = rec_ff; shift_in = shift_ff;
      addr_in = addr_ff; reg_in = reg_ff; len_in = len_ff; rd_in = rd_ff;
      qc_in = qc_ff; scl_in = scl_ff; sda_in = sda_ff; fst_in = fst_ff;
      qwe = 1'b0; qwa = qc_ff[QW-1:0];
      r = '0;
      ddone = 1'b0; wres = 2'd0; bgo = 1'b0; bval = 8'd0; bwr = 1'b1;

      if (q_valid && q_take) begin
         // shared timing helpers
         if ({2'b0, half_ff} + 10'd1 >= {2'b0, hlim}) ddone = 1'b1;
         if (q_cmd.scl_level) wres = 2'd1;
         else if (str_ff + 10'd1 >= slim) wres = 2'd2;

         if (op == i2cm_pkg::OP_TICK) begin
            if (phase_ff != i2cm_pkg::P_IDLE) begin
               if (phase_ff == i2cm_pkg::P_ST_D1 || phase_ff == i2cm_pkg::P_ST_D2 ||
                   phase_ff == i2cm_pkg::P_BY_D1 || phase_ff == i2cm_pkg::P_BY_D2 ||
                   phase_ff == i2cm_pkg::P_SP_D1 || phase_ff == i2cm_pkg::P_SP_D2 ||
                   phase_ff == i2cm_pkg::P_SP_D3 || phase_ff == i2cm_pkg::P_RC_D1 ||
                   phase_ff == i2cm_pkg::P_RC_D2)
                  half_in = ddone ? 8'd0 : half_ff + 8'd1;
               if (phase_ff == i2cm_pkg::P_ST_WAIT || phase_ff == i2cm_pkg::P_BY_WAIT ||
                   phase_ff == i2cm_pkg::P_SP_WAIT || phase_ff == i2cm_pkg::P_RC_WAIT0 ||
                   phase_ff == i2cm_pkg::P_RC_WAIT)
                  str_in = (wres == 2'd0) ? str_ff + 10'd1 : 10'd0;
               case (phase_ff)
                  i2cm_pkg::P_ST_REL: begin
                     sda_in = 1'b0; scl_in = 1'b0; str_in = 10'd0;
                     phase_in = i2cm_pkg::P_ST_WAIT;
                  end
                  i2cm_pkg::P_ST_WAIT: begin
                     if (wres == 2'd1) begin
                        half_in = 8'd0; phase_in = i2cm_pkg::P_ST_D1;
                     end else if (wres == 2'd2) begin
                        if (seg_ff == i2cm_pkg::SEG_START) begin
                           phase_in = i2cm_pkg::P_IDLE; half_in = 8'd0;
                           r.done_res = 1'b1; r.status = i2cm_pkg::ST_TIMEOUT;
                        end else begin
                           fst_in = i2cm_pkg::ST_TIMEOUT; sda_in = 1'b1; half_in = 8'd0;
                           phase_in = i2cm_pkg::P_SP_D1;
                        end
                     end
                  end
                  i2cm_pkg::P_ST_D1: begin
                     if (ddone) begin
                        if (!q_cmd.sda_level) begin
                           if (seg_ff == i2cm_pkg::SEG_START) begin
                              phase_in = i2cm_pkg::P_IDLE; str_in = 10'd0;
                              r.done_res = 1'b1; r.status = i2cm_pkg::ST_BUSY;
                           end else begin
                              fst_in = i2cm_pkg::ST_BUSY; sda_in = 1'b1;
                              phase_in = i2cm_pkg::P_SP_D1;
                           end
                        end else begin
                           sda_in = 1'b1; phase_in = i2cm_pkg::P_ST_D2;
                        end
                     end
                  end
                  i2cm_pkg::P_ST_D2: begin
                     if (ddone) begin
                        scl_in = 1'b1; bgo = 1'b1;
                        if (seg_ff == i2cm_pkg::SEG_START) begin
                           seg_in = i2cm_pkg::SEG_ADDR_W; bval = {addr_ff, 1'b0};
                        end else begin
                           seg_in = i2cm_pkg::SEG_ADDR_R; bval = {addr_ff, 1'b1};
                        end
                     end
                  end
                  i2cm_pkg::P_BY_D1: begin
                     if (ddone) begin
                        scl_in = 1'b0; str_in = 10'd0; phase_in = i2cm_pkg::P_BY_WAIT;
                     end
                  end
                  i2cm_pkg::P_BY_WAIT: begin
                     if (wres == 2'd1) begin
                        half_in = 8'd0; phase_in = i2cm_pkg::P_BY_D2;
                     end else if (wres == 2'd2) begin
                        fst_in = i2cm_pkg::ST_TIMEOUT; sda_in = 1'b1; half_in = 8'd0;
                        phase_in = i2cm_pkg::P_SP_D1;
                     end
                  end
                  i2cm_pkg::P_BY_D2: begin
                     if (ddone) begin
                        scl_in = 1'b1;
                        if (bit_ff < 4'd8) begin
                           if (!wr) shift_in = {shift_ff[6:0], q_cmd.sda_level};
                           bit_in = bit_ff + 4'd1;
                           if (bit_ff + 4'd1 < 4'd8)
                              sda_in = wr ? !shift_ff[3'd7 - bit_ff[2:0] - 3'd1] : 1'b0;
                           else
                              sda_in = wr ? 1'b0 : (byc_nx < len_ff);
                           phase_in = i2cm_pkg::P_BY_D1;
                        end else begin
                           if (!wr) sda_in = 1'b0;
                           case (seg_ff)
                              i2cm_pkg::SEG_ADDR_W: begin
                                 if (!ack) begin
                                    fst_in = i2cm_pkg::ST_ANACK; sda_in = 1'b1;
                                    phase_in = i2cm_pkg::P_SP_D1;
                                 end else begin
                                    seg_in = i2cm_pkg::SEG_REG; bgo = 1'b1; bval = reg_ff;
                                 end
                              end
                              i2cm_pkg::SEG_REG: begin
                                 if (!ack) begin
                                    fst_in = i2cm_pkg::ST_DNACK; sda_in = 1'b1;
                                    phase_in = i2cm_pkg::P_SP_D1;
                                 end else if (rd_ff) begin
                                    seg_in = i2cm_pkg::SEG_RSTART;
                                    phase_in = i2cm_pkg::P_ST_REL;
                                 end else if (len_ff == 5'd0) begin
                                    fst_in = i2cm_pkg::ST_OK; sda_in = 1'b1;
                                    phase_in = i2cm_pkg::P_SP_D1;
                                 end else begin
                                    seg_in = i2cm_pkg::SEG_DATA_W; byc_in = 5'd0;
                                    bgo = 1'b1; bval = q_at(5'd0, qrd);
                                 end
                              end
                              i2cm_pkg::SEG_DATA_W: begin
                                 if (!ack) begin
                                    fst_in = i2cm_pkg::ST_DNACK; sda_in = 1'b1;
                                    phase_in = i2cm_pkg::P_SP_D1;
                                 end else begin
                                    byc_in = byc_nx;
                                    if (byc_nx < len_ff) begin
                                       bgo = 1'b1; bval = q_at(byc_nx, qrd);
                                    end else begin
                                       fst_in = i2cm_pkg::ST_OK; sda_in = 1'b1;
                                       phase_in = i2cm_pkg::P_SP_D1;
                                    end
                                 end
                              end
                              i2cm_pkg::SEG_ADDR_R: begin
                                 if (!ack) begin
                                    fst_in = i2cm_pkg::ST_ANACK; sda_in = 1'b1;
                                    phase_in = i2cm_pkg::P_SP_D1;
                                 end else begin
                                    seg_in = i2cm_pkg::SEG_DATA_R; byc_in = 5'd0;
                                    bgo = 1'b1; bwr = 1'b0;
                                 end
                              end
                              default: begin
                                 r.read_valid = 1'b1; r.read_data = shift_ff;
                                 r.read_last = !(byc_nx < len_ff);
                                 byc_in = byc_nx;
                                 if (byc_nx < len_ff) begin
                                    bgo = 1'b1; bwr = 1'b0;
                                 end else begin
                                    fst_in = i2cm_pkg::ST_OK; sda_in = 1'b1;
                                    phase_in = i2cm_pkg::P_SP_D1;
                                 end
                              end
                           endcase
                        end
                     end
                  end
                  i2cm_pkg::P_SP_D1: begin
                     if (ddone) begin
                        scl_in = 1'b0; str_in = 10'd0; phase_in = i2cm_pkg::P_SP_WAIT;
                     end
                  end
                  i2cm_pkg::P_SP_WAIT: begin
                     if (wres != 2'd0) begin
                        half_in = 8'd0; phase_in = i2cm_pkg::P_SP_D2;
                     end
                  end
                  i2cm_pkg::P_SP_D2: begin
                     if (ddone) begin
                        sda_in = 1'b0; phase_in = i2cm_pkg::P_SP_D3;
                     end
                  end
                  i2cm_pkg::P_SP_D3: begin
                     if (ddone) begin
                        phase_in = i2cm_pkg::P_IDLE; str_in = 10'd0; r.done_res = 1'b1;
                        if (seg_ff == i2cm_pkg::SEG_RECOVER)
                           r.status = q_cmd.sda_level ? i2cm_pkg::ST_OK : i2cm_pkg::ST_BUSY;
                        else
                           r.status = fst_ff;
                     end
                  end
                  i2cm_pkg::P_RC_WAIT0, i2cm_pkg::P_RC_WAIT: begin
                     if (wres == 2'd1) begin
                        half_in = 8'd0;
                        if (phase_ff == i2cm_pkg::P_RC_WAIT) phase_in = i2cm_pkg::P_RC_D2;
                        else if (!q_cmd.sda_level && rec_ff < i2cm_pkg::RECOVERY_PULSES) begin
                           scl_in = 1'b1; phase_in = i2cm_pkg::P_RC_D1;
                        end else begin
                           fst_in = i2cm_pkg::ST_OK; sda_in = 1'b1;
                           phase_in = i2cm_pkg::P_SP_D1;
                        end
                     end else if (wres == 2'd2) begin
                        phase_in = i2cm_pkg::P_IDLE; half_in = 8'd0;
                        r.done_res = 1'b1; r.status = i2cm_pkg::ST_TIMEOUT;
                     end
                  end
                  i2cm_pkg::P_RC_D1: begin
                     if (ddone) begin
                        scl_in = 1'b0; str_in = 10'd0; phase_in = i2cm_pkg::P_RC_WAIT;
                     end
                  end
                  i2cm_pkg::P_RC_D2: begin
                     if (ddone) begin
                        rec_in = rec_ff + 4'd1;
                        if (!q_cmd.sda_level && rec_ff + 4'd1 < i2cm_pkg::RECOVERY_PULSES) begin
                           scl_in = 1'b1; phase_in = i2cm_pkg::P_RC_D1;
                        end else begin
                           fst_in = i2cm_pkg::ST_OK; sda_in = 1'b1;
                           phase_in = i2cm_pkg::P_SP_D1;
                        end
                     end
                  end
                  default: phase_in = i2cm_pkg::P_IDLE;
               endcase
               if (bgo) begin
                  shift_in = bwr ? bval : 8'd0; bit_in = 4'd0; half_in = 8'd0;
                  phase_in = i2cm_pkg::P_BY_D1; sda_in = bwr ? !bval[7] : 1'b0;
               end
            end
         end else if (phase_ff == i2cm_pkg::P_IDLE) begin
            case (op)
               i2cm_pkg::OP_QUEUE: begin
                  if (qc_ff < CW'(MaxTransfer)) begin
                     qwe = 1'b1; qc_in = qc_ff + CW'(1); r.accepted = 1'b1;
                  end
               end
               i2cm_pkg::OP_RECOVER: begin
                  r.accepted = 1'b1; seg_in = i2cm_pkg::SEG_RECOVER; rec_in = 4'd0;
                  sda_in = 1'b0; scl_in = 1'b0; str_in = 10'd0;
                  phase_in = i2cm_pkg::P_RC_WAIT0;
               end
               i2cm_pkg::OP_WRITE, i2cm_pkg::OP_READ: begin
                  r.accepted = 1'b1;
                  if (op == i2cm_pkg::OP_WRITE) qc_in = '0;
                  if ({27'd0, q_cmd.byte_count} > MaxTransfer ||
                      (op == i2cm_pkg::OP_WRITE ? ({27'd0, q_cmd.byte_count} > 32'(qc_ff))
                                                : (q_cmd.byte_count == 5'd0))) begin
                     r.done_res = 1'b1; r.status = i2cm_pkg::ST_INVALID;
                  end else begin
                     addr_in = q_cmd.device_address; reg_in = q_cmd.register_index;
                     len_in = q_cmd.byte_count; rd_in = (op == i2cm_pkg::OP_READ);
                     byc_in = 5'd0; seg_in = i2cm_pkg::SEG_START;
                     sda_in = 1'b0; scl_in = 1'b0; str_in = 10'd0; half_in = 8'd0;
                     phase_in = i2cm_pkg::P_ST_WAIT;
                  end
               end
               default: ;
            endcase
         end
      end
      r.scl_drive_low = scl_in;
      r.sda_drive_low = sda_in;
      r.busy_res      = (phase_in != i2cm_pkg::P_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= i2cm_pkg::P_IDLE; seg_ff <= i2cm_pkg::SEG_START;
         half_ff <= '0; str_ff <= '0; bit_ff <= '0; byc_ff <= '0; rec_ff <= '0;
         shift_ff <= '0; addr_ff <= '0; reg_ff <= '0; len_ff <= '0; rd_ff <= 1'b0;
         qc_ff <= '0; scl_ff <= 1'b0; sda_ff <= 1'b0; fst_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; seg_ff <= seg_in;
         half_ff <= half_in; str_ff <= str_in; bit_ff <= bit_in; byc_ff <= byc_in;
         rec_ff <= rec_in; shift_ff <= shift_in; addr_ff <= addr_in; reg_ff <= reg_in;
         len_ff <= len_in; rd_ff <= rd_in; qc_ff <= qc_in;
         scl_ff <= scl_in; sda_ff <= sda_in; fst_ff <= fst_in;
         if (q_take) ovalid_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (q_take && q_valid) orsp_ff <= r;
      if (qwe) queue_mem[qwa] <= q_cmd.write_data;
   end
endmodule

[rtl/i2c_master_register_access.sv]
// Input transfers are registered in the command queue, and the result register loads when
// the engine takes the queue head. One item per cycle unless the result register stalls.
// Two-entry command queue decouples the input from the result register stall.
// Synchronous reset: bus lines released, idle, timers and queue count zero,
// half period 4 ticks, stretch timeout 1000 ticks.
module i2c_master_register_access #(
   parameter int MaxTransfer = i2cm_pkg::MaxTransferDefault
) (
   input logic clock,
   input logic reset,
   i2cm_req_if.sink   req,
   i2cm_rsp_if.source rsp,
   i2cm_csr_if.sink   csr
);
   logic [7:0] half_ff;
   logic [9:0] stretch_ff;
   logic       q_valid, q_take;
   i2cm_pkg::cmd_type q_cmd;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff    <= 8'd4;
         stretch_ff <= 10'd1000;
      end else if (csr.valid) begin
         if (csr.index == i2cm_pkg::CSR_HALF) half_ff <= csr.data[7:0];
         else stretch_ff <= csr.data;
      end
   end

   i2cm_front u_front (
      .clock, .reset,
      .in_valid (req.valid), .in_ready (req.ready), .in_cmd (req.payload),
      .q_valid, .q_take, .q_cmd
   );

   i2cm_engine #(.MaxTransfer (MaxTransfer)) u_engine (
      .clock, .reset, .q_valid, .q_take, .q_cmd,
      .half_period (half_ff), .stretch_limit (stretch_ff),
      .out_valid (rsp.valid), .out_ready (rsp.ready), .out_rsp (rsp.payload)
   );

   a_status_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.payload.done_res |-> rsp.payload.status == i2cm_pkg::ST_OK)
      else $error("status without done");
   a_last_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.read_last |-> rsp.payload.read_valid)
      else $error("read_last without read_valid");
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.done_res |-> !rsp.payload.busy_res)
      else $error("done while busy");
endmodule
